FILE: rtl/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define LAPT_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define LAPT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/lapt_pkg.sv
// shared constants, widths and controller interface types
`timescale 1ns / 1ps

package lapt_pkg;

    localparam int DEF_SAMPLES_PER_PACKET = 16;
    localparam int DEF_PACKETS_PER_WINDOW = 3;
    localparam int DEF_TICKS_PER_SECOND   = 8192;

    localparam int MODE_W   = 2;
    localparam int SAMPLE_W = 32;
    localparam int GAIN_W   = 31;
    localparam int SEC_W    = 18;
    localparam int TIME_W   = 64;
    localparam int PKT_W    = 2;
    localparam int SUM_W    = SAMPLE_W + 1;
    localparam int SCALE_W  = 15;
    localparam int PROD_W   = 48;
    localparam int REM_W    = GAIN_W;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = MODE_W;
    localparam int M_TDATA_W = 72;

    localparam logic signed [SCALE_W-1:0] GRAM_SCALE = 15'sd10000;

    localparam logic [MODE_W-1:0] MODE_SAMPLE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TICK   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_OFF    = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] REG_ZERO_OFFSET      = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_DIVISOR     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SPREAD_THRESHOLD = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_HIGH_THRESHOLD   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_ON_SECONDS       = 3'd4;

    typedef struct packed {
        logic load_item;
        logic update;
        logic mul_go;
        logic mul_min;
        logic div_start;
        logic store_max;
        logic store_min;
        logic eval;
        logic timeout;
        logic out_load;
    } lapt_cmd_t;

    typedef struct packed {
        logic win_close;
        logic div_busy;
        logic div_done;
    } lapt_sts_t;

endpackage

FILE: rtl/lapt_div.sv
// bit-serial restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module lapt_div (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [lapt_pkg::PROD_W-1:0]    dividend,
    input  logic [lapt_pkg::GAIN_W-1:0]    divisor,
    output logic                           busy,
    output logic                           done,
    output logic [lapt_pkg::PROD_W-1:0]    quotient
);
    import lapt_pkg::*;

    localparam int CNT_W = $clog2(PROD_W + 1);

    logic [PROD_W-1:0] quo_reg, quo_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [GAIN_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [REM_W:0]    rem_sh;
    logic [REM_W+1:0]  trial;

    assign rem_sh = {rem_reg, quo_reg[PROD_W-1]};
    assign trial  = {1'b0, rem_sh} - {2'b00, dvs_reg};

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = CNT_W'(PROD_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[REM_W+1]) begin
                rem_next = trial[REM_W-1:0];
                quo_next = {quo_reg[PROD_W-2:0], 1'b1};
            end else begin
                rem_next = rem_sh[REM_W-1:0];
                quo_next = {quo_reg[PROD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: rtl/lapt_dp.sv
// datapath: config registers, window tracking, gram conversion, power timer
`timescale 1ns / 1ps

module lapt_dp #(
    parameter int SAMPLES_PER_PACKET = lapt_pkg::DEF_SAMPLES_PER_PACKET,
    parameter int PACKETS_PER_WINDOW = lapt_pkg::DEF_PACKETS_PER_WINDOW,
    parameter int TICKS_PER_SECOND   = lapt_pkg::DEF_TICKS_PER_SECOND
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [lapt_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [lapt_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic [lapt_pkg::MODE_W-1:0]       in_mode,
    input  logic [lapt_pkg::SAMPLE_W-1:0]     in_sample,
    input  lapt_pkg::lapt_cmd_t               cmd,
    output lapt_pkg::lapt_sts_t               sts,
    output logic [lapt_pkg::M_TDATA_W-1:0]    out_data
);
    import lapt_pkg::*;

    localparam int IDX_W  = $clog2(SAMPLES_PER_PACKET + 1);
    localparam int HOLD_W = SEC_W + $clog2(TICKS_PER_SECOND + 1);
    localparam int PAD_W  = M_TDATA_W - 3 - 2 * SAMPLE_W;

    // configuration
    logic signed [SAMPLE_W-1:0] offset_reg;
    logic [GAIN_W-1:0]          gain_reg;
    logic signed [SAMPLE_W-1:0] spread_thr_reg;
    logic signed [SAMPLE_W-1:0] high_thr_reg;
    logic [SEC_W-1:0]           on_sec_reg;

    // item and block state
    logic [MODE_W-1:0]          mode_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic signed [SAMPLE_W-1:0] win_max_reg, win_min_reg;
    logic [IDX_W-1:0]           idx_reg;
    logic [PKT_W-1:0]           pkt_reg;
    logic [TIME_W-1:0]          now_reg, deadline_reg;
    logic                       power_reg;

    // conversion
    logic [HOLD_W-1:0]          hold_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic                       neg_reg;
    logic signed [SAMPLE_W-1:0] gmax_reg, gmin_reg;
    logic                       done_reg, active_reg;
    logic [M_TDATA_W-1:0]       out_data_reg;

    logic [IDX_W-1:0]           idx_inc;
    logic [PKT_W-1:0]           pkt_inc;
    logic                       idx_wrap, pkt_wrap;
    logic signed [SAMPLE_W-1:0] mul_src;
    logic signed [SUM_W-1:0]    sum;
    logic signed [PROD_W-1:0]   prod_next;
    logic [PROD_W-1:0]          mag;
    logic [GAIN_W-1:0]          dvs;
    logic                       div_busy, div_done;
    logic [PROD_W-1:0]          quo;
    logic [SAMPLE_W-1:0]        quo_lo, grams;
    logic signed [SUM_W-1:0]    spread;
    logic                       act;
    logic [TIME_W-1:0]          to_diff;
    logic                       expired;

    assign idx_inc  = idx_reg + 1'b1;
    assign pkt_inc  = pkt_reg + 1'b1;
    assign idx_wrap = idx_inc >= IDX_W'(SAMPLES_PER_PACKET);
    assign pkt_wrap = pkt_inc >= PKT_W'(PACKETS_PER_WINDOW);

    assign sts.win_close = (mode_reg == MODE_SAMPLE) && idx_wrap && pkt_wrap;
    assign sts.div_busy  = div_busy;
    assign sts.div_done  = div_done;

    assign mul_src   = cmd.mul_min ? win_min_reg : win_max_reg;
    assign sum       = SUM_W'(mul_src) + SUM_W'(offset_reg);
    assign prod_next = PROD_W'(sum) * GRAM_SCALE;

    assign mag = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
    assign dvs = (gain_reg == '0) ? GAIN_W'(1) : gain_reg;

    lapt_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (mag),
        .divisor  (dvs),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (quo)
    );

    assign quo_lo = quo[SAMPLE_W-1:0];
    assign grams  = neg_reg ? (~quo_lo + 1'b1) : quo_lo;

    assign spread = SUM_W'(gmax_reg) - SUM_W'(gmin_reg);
    assign act    = (spread > SUM_W'(spread_thr_reg)) || (gmax_reg > high_thr_reg);

    assign to_diff = now_reg - deadline_reg;
    assign expired = (to_diff != '0) && !to_diff[TIME_W-1];

    // control and block state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg     <= '0;
            gain_reg       <= GAIN_W'(1);
            spread_thr_reg <= '0;
            high_thr_reg   <= '0;
            on_sec_reg     <= '0;
            win_max_reg    <= {1'b1, {(SAMPLE_W-1){1'b0}}};
            win_min_reg    <= {1'b0, {(SAMPLE_W-1){1'b1}}};
            idx_reg        <= '0;
            pkt_reg        <= '0;
            now_reg        <= '0;
            deadline_reg   <= '0;
            power_reg      <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_ZERO_OFFSET:      offset_reg     <= cfg_wdata;
                    REG_GAIN_DIVISOR:     gain_reg       <= cfg_wdata[GAIN_W-1:0];
                    REG_SPREAD_THRESHOLD: spread_thr_reg <= cfg_wdata;
                    REG_HIGH_THRESHOLD:   high_thr_reg   <= cfg_wdata;
                    REG_ON_SECONDS:       on_sec_reg     <= cfg_wdata[SEC_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.update) begin
                case (mode_reg)
                    MODE_SAMPLE: begin
                        if (sample_reg > win_max_reg) begin
                            win_max_reg <= sample_reg;
                        end
                        if (sample_reg < win_min_reg) begin
                            win_min_reg <= sample_reg;
                        end
                        if (idx_wrap) begin
                            idx_reg <= '0;
                            pkt_reg <= pkt_wrap ? '0 : pkt_inc;
                        end else begin
                            idx_reg <= idx_inc;
                        end
                    end
                    MODE_TICK: begin
                        now_reg <= now_reg + 1'b1;
                    end
                    MODE_OFF: begin
                        power_reg    <= 1'b0;
                        deadline_reg <= now_reg;
                    end
                    default: ;
                endcase
            end
            if (cmd.eval) begin
                win_max_reg <= {1'b1, {(SAMPLE_W-1){1'b0}}};
                win_min_reg <= {1'b0, {(SAMPLE_W-1){1'b1}}};
                if (act) begin
                    power_reg    <= 1'b1;
                    deadline_reg <= now_reg + TIME_W'(hold_reg);
                end
            end
            if (cmd.timeout && expired) begin
                power_reg    <= 1'b0;
                deadline_reg <= now_reg + TIME_W'(TICKS_PER_SECOND);
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        hold_reg <= HOLD_W'(on_sec_reg) * HOLD_W'(TICKS_PER_SECOND);
        if (cmd.load_item) begin
            mode_reg   <= in_mode;
            sample_reg <= in_sample;
            gmax_reg   <= '0;
            gmin_reg   <= '0;
            done_reg   <= 1'b0;
            active_reg <= 1'b0;
        end
        if (cmd.update) begin
            done_reg <= sts.win_close;
        end
        if (cmd.mul_go) begin
            prod_reg <= prod_next;
        end
        if (cmd.div_start) begin
            neg_reg <= prod_reg[PROD_W-1];
        end
        if (cmd.store_max) begin
            gmax_reg <= grams;
        end
        if (cmd.store_min) begin
            gmin_reg <= grams;
        end
        if (cmd.eval) begin
            active_reg <= act;
        end
        if (cmd.out_load) begin
            out_data_reg <= {{PAD_W{1'b0}}, gmin_reg, gmax_reg,
                             active_reg, done_reg, power_reg};
        end
    end

    assign out_data = out_data_reg;

endmodule

FILE: rtl/lapt_ctrl.sv
// controller state machine sequencing one transaction through the datapath
`timescale 1ns / 1ps

module lapt_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  lapt_pkg::lapt_sts_t   sts,
    output lapt_pkg::lapt_cmd_t   cmd
);
    import lapt_pkg::*;

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_UPDATE  = 4'd1;
    localparam logic [3:0] ST_MUL_MAX = 4'd2;
    localparam logic [3:0] ST_DST_MAX = 4'd3;
    localparam logic [3:0] ST_DWT_MAX = 4'd4;
    localparam logic [3:0] ST_MUL_MIN = 4'd5;
    localparam logic [3:0] ST_DST_MIN = 4'd6;
    localparam logic [3:0] ST_DWT_MIN = 4'd7;
    localparam logic [3:0] ST_EVAL    = 4'd8;
    localparam logic [3:0] ST_TIMEOUT = 4'd9;
    localparam logic [3:0] ST_OUTPUT  = 4'd10;

    logic [3:0] state_reg, state_next;
    logic       mvalid_reg, mvalid_next;
    logic       out_free;

    assign out_free = !mvalid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                state_next = sts.win_close ? ST_MUL_MAX : ST_TIMEOUT;
            end
            ST_MUL_MAX: begin
                cmd.mul_go = 1'b1;
                state_next = ST_DST_MAX;
            end
            ST_DST_MAX: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DWT_MAX;
            end
            ST_DWT_MAX: begin
                cmd.store_max = sts.div_done;
                if (sts.div_done) begin
                    state_next = ST_MUL_MIN;
                end
            end
            ST_MUL_MIN: begin
                cmd.mul_go  = 1'b1;
                cmd.mul_min = 1'b1;
                state_next  = ST_DST_MIN;
            end
            ST_DST_MIN: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DWT_MIN;
            end
            ST_DWT_MIN: begin
                cmd.store_min = sts.div_done;
                if (sts.div_done) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                cmd.eval   = 1'b1;
                state_next = ST_TIMEOUT;
            end
            ST_TIMEOUT: begin
                cmd.timeout = 1'b1;
                state_next  = ST_OUTPUT;
            end
            ST_OUTPUT: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        mvalid_next = mvalid_reg;
        if (cmd.out_load) begin
            mvalid_next = 1'b1;
        end else if (m_tready) begin
            mvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mvalid_reg;

endmodule

FILE: rtl/load_activity_power_timeout.sv
// top level: load-cell activity power timeout
//
// input stream: s_tuser carries the item kind (load sample, time tick, forced
// power-off), s_tdata the signed raw sample. each accepted transaction yields
// exactly one result transaction on the m_ side carrying the power state, the
// window-closed and activity flags and the converted window extremes in grams.
// configuration: cfg_wr_en with cfg_addr selects one of five registers
// (offset, gain divisor, spread threshold, high threshold, on seconds), to be
// written only while the block is idle; the block does not enforce this.
// ticks, power-off items and samples that do not close a window pass through
// the update, timeout and output states; a sample that closes a window also
// takes two passes of the 48-step bit-serial divider, then the eval state.
// one transaction is worked on at a time; the next is accepted once the
// previous result sits in the output register.
// a stalled receiver holds the result in the output register; a second
// item can be accepted and processed meanwhile, but its result waits until
// the first transaction completes.
// reset (aresetn low, synchronous) restores the register defaults, empties
// the window, zeroes time and deadline and switches power off.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module load_activity_power_timeout #(
    parameter int SAMPLES_PER_PACKET = lapt_pkg::DEF_SAMPLES_PER_PACKET,
    parameter int PACKETS_PER_WINDOW = lapt_pkg::DEF_PACKETS_PER_WINDOW,
    parameter int TICKS_PER_SECOND   = lapt_pkg::DEF_TICKS_PER_SECOND
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [lapt_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [lapt_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [lapt_pkg::S_TDATA_W-1:0]   s_tdata,   // sample[31:0]
    input  logic [lapt_pkg::S_TUSER_W-1:0]   s_tuser,   // mode[1:0]
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // power_on[0], window_done[1], activity_found[2], max_grams[34:3],
    // min_grams[66:35], zero fill above
    output logic [lapt_pkg::M_TDATA_W-1:0]   m_tdata
);
    import lapt_pkg::*;

    lapt_cmd_t cmd;
    lapt_sts_t sts;

    lapt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lapt_dp #(
        .SAMPLES_PER_PACKET (SAMPLES_PER_PACKET),
        .PACKETS_PER_WINDOW (PACKETS_PER_WINDOW),
        .TICKS_PER_SECOND   (TICKS_PER_SECOND)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_mode   (s_tuser),
        .in_sample (s_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .out_data  (m_tdata)
    );

    `LAPT_ASSERT_NOW(a_grams_only_on_window, aclk, aresetn,
        m_tvalid && !m_tdata[1], m_tdata[66:3] == '0, "grams set without closed window")
    `LAPT_ASSERT_NOW(a_activity_needs_window, aclk, aresetn,
        m_tvalid && m_tdata[2], m_tdata[1], "activity flagged without closed window")
    `LAPT_ASSERT_NOW(a_div_start_idle, aclk, aresetn,
        cmd.div_start, !sts.div_busy, "divider restarted while busy")
    `LAPT_ASSERT_NEXT(a_one_item_at_a_time, aclk, aresetn,
        cmd.load_item, !s_tready, "new transaction accepted while one is in flight")

endmodule
